@@ hdl/nmhm_pkg.sv @@
`default_nettype none
package nmhm_pkg;

  localparam int unsigned NODE_COUNT = 16;
  localparam logic [10:0] HB_BASE = 11'h700;
  localparam logic [31:0] BOOT_TIME_RESET = 32'd10000;
  localparam int unsigned FLAG_START_BIT = 0;
  localparam int unsigned FLAG_NO_AUTOSTART_BIT = 3;

  localparam logic [2:0] KIND_CONFIG = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_FRAME = 3'd2;
  localparam logic [2:0] KIND_TICK = 3'd3;
  localparam logic [2:0] KIND_REQUEST = 3'd4;

  localparam logic [1:0] RK_EVENT = 2'd0;
  localparam logic [1:0] RK_FRAME = 2'd1;
  localparam logic [1:0] RK_STATUS = 2'd2;

  localparam logic [2:0] EV_INVALID = 3'd0;
  localparam logic [2:0] EV_BOOTUP = 3'd1;
  localparam logic [2:0] EV_HEARTBEAT = 3'd2;
  localparam logic [2:0] EV_HB_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_BOOT_TIMEOUT = 3'd4;
  localparam logic [2:0] EV_READY = 3'd5;

  localparam logic [2:0] NS_WAIT = 3'd0;
  localparam logic [2:0] NS_PREOP = 3'd1;
  localparam logic [2:0] NS_OPER = 3'd2;
  localparam logic [2:0] NS_STOP = 3'd3;
  localparam logic [2:0] NS_TMO = 3'd4;

  localparam logic [7:0] HB_BOOTUP = 8'd0;
  localparam logic [7:0] HB_STOPPED = 8'd4;
  localparam logic [7:0] HB_OPER = 8'd5;
  localparam logic [7:0] HB_PREOP = 8'd127;

  localparam logic [7:0] NMT_START = 8'd1;
  localparam logic [7:0] NMT_STOP = 8'd2;
  localparam logic [7:0] NMT_PREOP = 8'd128;
  localparam logic [7:0] NMT_RESET_NODE = 8'd129;
  localparam logic [7:0] NMT_RESET_COMM = 8'd130;

  localparam logic [1:0] CFG_MASTER_ID = 2'd0;
  localparam logic [1:0] CFG_BOOT_TIME = 2'd1;
  localparam logic [1:0] CFG_FLAGS = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  node_id;
    logic        mandatory;
    logic        autostart_en;
    logic [15:0] hb_limit;
    logic [10:0] can_id;
    logic [3:0]  dlc;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;
    logic [7:0]  command;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  event_type;
    logic [6:0]  event_node;
    logic [7:0]  event_state;
    logic [31:0] event_time;
    logic [7:0]  nmt_command;
    logic        accepted;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CONFIG, CMD_START, CMD_START_STEP, CMD_FRAME, CMD_REQ_FRAME,
    CMD_REQ_STATUS, CMD_TICK_INIT, CMD_TMO_STEP, CMD_RDY_STEP, CMD_BOOT_EMIT,
    CMD_READY_EMIT, CMD_AS_STEP, CMD_FLUSH
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_START_WALK, S_REQ2, S_TMO_WALK, S_RDY_WALK, S_DECIDE,
    S_AS_WALK, S_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic       running;
    logic       flag_start;
    logic       flag_noauto;
    logic       req_ok;
    logic       idx_last;
    logic       can_emit;
    logic       pend_v;
    logic       out_v;
    logic       bt_cond;
    logic       found;
    logic       ready_go;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/nmhm_stream_if.sv @@
`default_nettype none
interface nmhm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/nmt_master_heartbeat_monitor_unit.sv @@
`default_nettype none
// nmt master with heartbeat consumer
// in_if carries one request item per transfer: configure node, start, received
// frame, time tick or nmt command request. out_if carries result items (events,
// nmt frames to send, call status); the final result of an item has last set.
// items that cause no result produce no transfer on out_if.
// cfg_we_i/cfg_idx_i/cfg_data_i write master id (0), boot time (1) and startup
// flags (2); write only while the block is idle.
// steps from one accepted item to the next with no stall: idle, execute, flush for a
// single-step item; idle, execute, second request step, flush for an accepted
// request; a time tick walks the node table twice (timeout pass, readiness pass)
// and a third time for auto-start frames; start walks the table once.
// one item at a time; in_if.ready is high only while idle.
// results go through a pending slot and an output register, so the block can
// go idle and take the next item while the last result still waits on out_if.
// a stalled receiver holds the walk at the next result to be produced.
// reset clears the node table, run state, times and configuration (boot time
// back to 10000 ms); no clearing pass is needed.
module nmt_master_heartbeat_monitor_unit #(
  parameter int unsigned NodeCount = nmhm_pkg::NODE_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  nmhm_stream_if.sink      in_if,
  nmhm_stream_if.source    out_if
);

  nmhm_pkg::cmd_e       cmd;
  nmhm_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 in_fire;

  assign in_if.ready = in_ready;
  assign in_fire = in_if.valid && in_ready;

  // sequencer: one item at a time, waits on the result slots
  nmhm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .st_i       (status),
    .in_fire_i  (in_fire),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  // node table, run state and result buffering
  nmhm_datapath #(
    .NodeCount (NodeCount)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .in_item_i   (in_if.data),
    .cmd_i       (cmd),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_res_o   (out_if.data),
    .st_o        (status)
  );

endmodule
`default_nettype wire

@@ hdl/nmhm_ctrl.sv @@
`default_nettype none
module nmhm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire nmhm_pkg::dp_status_t st_i,
  input  wire logic               in_fire_i,
  output nmhm_pkg::cmd_e          cmd_o,
  output logic                    in_ready_o
);

  nmhm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= nmhm_pkg::S_IDLE;
    else state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nmhm_pkg::S_IDLE: if (in_fire_i) state_d = nmhm_pkg::S_EXEC;
      nmhm_pkg::S_EXEC: begin
        if (st_i.can_emit) begin
          case (st_i.kind)
            nmhm_pkg::KIND_START:
              state_d = st_i.flag_start ? nmhm_pkg::S_START_WALK : nmhm_pkg::S_FLUSH;
            nmhm_pkg::KIND_TICK:
              state_d = st_i.running ? nmhm_pkg::S_TMO_WALK : nmhm_pkg::S_FLUSH;
            nmhm_pkg::KIND_REQUEST:
              state_d = st_i.req_ok ? nmhm_pkg::S_REQ2 : nmhm_pkg::S_FLUSH;
            default: state_d = nmhm_pkg::S_FLUSH;
          endcase
        end
      end
      nmhm_pkg::S_REQ2: if (st_i.can_emit) state_d = nmhm_pkg::S_FLUSH;
      nmhm_pkg::S_START_WALK: if (st_i.idx_last) state_d = nmhm_pkg::S_FLUSH;
      nmhm_pkg::S_TMO_WALK:
        if (st_i.can_emit && st_i.idx_last) state_d = nmhm_pkg::S_RDY_WALK;
      nmhm_pkg::S_RDY_WALK: if (st_i.idx_last) state_d = nmhm_pkg::S_DECIDE;
      nmhm_pkg::S_DECIDE: begin
        if (st_i.can_emit) begin
          if (st_i.bt_cond) state_d = nmhm_pkg::S_FLUSH;
          else if (st_i.ready_go && !st_i.flag_noauto) state_d = nmhm_pkg::S_AS_WALK;
          else state_d = nmhm_pkg::S_FLUSH;
        end
      end
      nmhm_pkg::S_AS_WALK:
        if (st_i.can_emit && st_i.idx_last) state_d = nmhm_pkg::S_FLUSH;
      nmhm_pkg::S_FLUSH: if (!st_i.pend_v || !st_i.out_v) state_d = nmhm_pkg::S_IDLE;
      default: state_d = nmhm_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = nmhm_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      nmhm_pkg::S_IDLE: in_ready_o = 1'b1;
      nmhm_pkg::S_EXEC: begin
        if (st_i.can_emit) begin
          case (st_i.kind)
            nmhm_pkg::KIND_CONFIG: cmd_o = nmhm_pkg::CMD_CONFIG;
            nmhm_pkg::KIND_START: cmd_o = nmhm_pkg::CMD_START;
            nmhm_pkg::KIND_FRAME:
              if (st_i.running) cmd_o = nmhm_pkg::CMD_FRAME;
            nmhm_pkg::KIND_TICK:
              if (st_i.running) cmd_o = nmhm_pkg::CMD_TICK_INIT;
            nmhm_pkg::KIND_REQUEST:
              cmd_o = st_i.req_ok ? nmhm_pkg::CMD_REQ_FRAME : nmhm_pkg::CMD_REQ_STATUS;
            default: cmd_o = nmhm_pkg::CMD_NONE;
          endcase
        end
      end
      nmhm_pkg::S_REQ2: if (st_i.can_emit) cmd_o = nmhm_pkg::CMD_REQ_STATUS;
      nmhm_pkg::S_START_WALK: cmd_o = nmhm_pkg::CMD_START_STEP;
      nmhm_pkg::S_TMO_WALK: if (st_i.can_emit) cmd_o = nmhm_pkg::CMD_TMO_STEP;
      nmhm_pkg::S_RDY_WALK: cmd_o = nmhm_pkg::CMD_RDY_STEP;
      nmhm_pkg::S_DECIDE: begin
        if (st_i.can_emit) begin
          if (st_i.bt_cond) begin
            if (st_i.found) cmd_o = nmhm_pkg::CMD_BOOT_EMIT;
          end else if (st_i.ready_go) begin
            cmd_o = nmhm_pkg::CMD_READY_EMIT;
          end
        end
      end
      nmhm_pkg::S_AS_WALK: if (st_i.can_emit) cmd_o = nmhm_pkg::CMD_AS_STEP;
      nmhm_pkg::S_FLUSH:
        if (st_i.pend_v && !st_i.out_v) cmd_o = nmhm_pkg::CMD_FLUSH;
      default: cmd_o = nmhm_pkg::CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/nmhm_datapath.sv @@
`default_nettype none
module nmhm_datapath #(
  parameter int unsigned NodeCount = nmhm_pkg::NODE_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 in_fire_i,
  input  wire nmhm_pkg::in_item_t   in_item_i,
  input  wire nmhm_pkg::cmd_e       cmd_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output nmhm_pkg::res_t            out_res_o,
  output nmhm_pkg::dp_status_t      st_o
);

  localparam int unsigned IW = $clog2(NodeCount + 1);
  localparam int unsigned Depth = NodeCount + 1;

  // configuration
  logic [6:0]  mid_q;
  logic [31:0] boot_q, flags_q;

  // item and globals
  nmhm_pkg::in_item_t item_q;
  logic        running_q, nready_q, btr_q;
  logic [31:0] start_q, latest_q;

  // node table, entry 0 is never assigned
  logic        asg_q  [Depth];
  logic        mand_q [Depth];
  logic        auto_q [Depth];
  logic [15:0] hbt_q  [Depth];
  logic [2:0]  nst_q  [Depth];
  logic [31:0] lhb_q  [Depth];

  // walk counter and scan results
  logic [IW-1:0] idx_q, first_q;
  logic          any_q, rdy_q, found_q;

  // pending result and output register
  nmhm_pkg::res_t pend_q, out_q;
  logic           pend_v_q, out_v_q;
  nmhm_pkg::res_t pend_last;

  logic           emit;
  nmhm_pkg::res_t emit_res;
  logic [IW-1:0]  cfg_node, fid;
  logic           frame_ok, needs_boot, tmo_hit;
  logic [31:0]    hb_age;

  assign cfg_node = item_q.node_id[IW-1:0];
  assign fid = IW'(item_q.can_id - nmhm_pkg::HB_BASE);
  assign frame_ok = (item_q.dlc == 4'd1) && (item_q.can_id >= nmhm_pkg::HB_BASE) &&
                    (item_q.can_id <= 11'(nmhm_pkg::HB_BASE + 11'(NodeCount)));
  assign needs_boot = asg_q[idx_q] && mand_q[idx_q] &&
                      (nst_q[idx_q] == nmhm_pkg::NS_WAIT || nst_q[idx_q] == nmhm_pkg::NS_TMO);
  assign hb_age = latest_q - lhb_q[idx_q];
  assign tmo_hit = asg_q[idx_q] && (hbt_q[idx_q] != 16'd0) &&
                   (hb_age > {16'd0, hbt_q[idx_q]}) && (nst_q[idx_q] != nmhm_pkg::NS_TMO);

  // pending result marked as the final one of its item
  always_comb begin
    pend_last = pend_q;
    pend_last.last = 1'b1;
  end

  always_comb begin
    st_o.kind        = item_q.kind;
    st_o.running     = running_q;
    st_o.flag_start  = flags_q[nmhm_pkg::FLAG_START_BIT];
    st_o.flag_noauto = flags_q[nmhm_pkg::FLAG_NO_AUTOSTART_BIT];
    st_o.req_ok      = (item_q.command == nmhm_pkg::NMT_START ||
                        item_q.command == nmhm_pkg::NMT_STOP ||
                        item_q.command == nmhm_pkg::NMT_PREOP ||
                        item_q.command == nmhm_pkg::NMT_RESET_NODE ||
                        item_q.command == nmhm_pkg::NMT_RESET_COMM) &&
                       (item_q.node_id <= 7'(NodeCount));
    st_o.idx_last    = (idx_q == IW'(NodeCount));
    st_o.can_emit    = !pend_v_q || !out_v_q;
    st_o.pend_v      = pend_v_q;
    st_o.out_v       = out_v_q;
    st_o.bt_cond     = !rdy_q && (boot_q != 32'd0) && !btr_q &&
                       ((latest_q - start_q) > boot_q);
    st_o.found       = found_q;
    st_o.ready_go    = !nready_q && any_q && rdy_q;
  end

  // result produced by the current command
  always_comb begin
    emit = 1'b0;
    emit_res = '0;
    emit_res.event_time = latest_q;
    case (cmd_i)
      nmhm_pkg::CMD_CONFIG: begin
        emit = 1'b1;
        emit_res.result_kind = nmhm_pkg::RK_STATUS;
        emit_res.accepted = (item_q.node_id != 7'd0) &&
                            (item_q.node_id <= 7'(NodeCount)) && (item_q.node_id != mid_q);
      end
      nmhm_pkg::CMD_START: begin
        emit = 1'b1;
        emit_res.result_kind = nmhm_pkg::RK_STATUS;
        emit_res.accepted = flags_q[nmhm_pkg::FLAG_START_BIT];
        if (flags_q[nmhm_pkg::FLAG_START_BIT]) emit_res.event_time = item_q.now_ms;
      end
      nmhm_pkg::CMD_FRAME: begin
        emit_res.event_time = item_q.now_ms;
        emit_res.result_kind = nmhm_pkg::RK_EVENT;
        if (!frame_ok) begin
          emit = 1'b1;
          emit_res.event_type = nmhm_pkg::EV_INVALID;
        end else if (asg_q[fid]) begin
          emit = 1'b1;
          emit_res.event_node = 7'(fid);
          emit_res.event_state = item_q.data_byte;
          case (item_q.data_byte)
            nmhm_pkg::HB_BOOTUP: emit_res.event_type = nmhm_pkg::EV_BOOTUP;
            nmhm_pkg::HB_PREOP, nmhm_pkg::HB_OPER, nmhm_pkg::HB_STOPPED:
              emit_res.event_type = nmhm_pkg::EV_HEARTBEAT;
            default: emit_res.event_type = nmhm_pkg::EV_INVALID;
          endcase
        end
      end
      nmhm_pkg::CMD_REQ_FRAME: begin
        emit = 1'b1;
        emit_res.result_kind = nmhm_pkg::RK_FRAME;
        emit_res.event_node = item_q.node_id;
        emit_res.nmt_command = item_q.command;
      end
      nmhm_pkg::CMD_REQ_STATUS: begin
        emit = 1'b1;
        emit_res.result_kind = nmhm_pkg::RK_STATUS;
        emit_res.accepted = st_o.req_ok;
      end
      nmhm_pkg::CMD_TMO_STEP: begin
        emit = tmo_hit;
        emit_res.result_kind = nmhm_pkg::RK_EVENT;
        emit_res.event_type = nmhm_pkg::EV_HB_TIMEOUT;
        emit_res.event_node = 7'(idx_q);
      end
      nmhm_pkg::CMD_BOOT_EMIT: begin
        emit = 1'b1;
        emit_res.result_kind = nmhm_pkg::RK_EVENT;
        emit_res.event_type = nmhm_pkg::EV_BOOT_TIMEOUT;
        emit_res.event_node = 7'(first_q);
      end
      nmhm_pkg::CMD_READY_EMIT: begin
        emit = 1'b1;
        emit_res.result_kind = nmhm_pkg::RK_EVENT;
        emit_res.event_type = nmhm_pkg::EV_READY;
      end
      nmhm_pkg::CMD_AS_STEP: begin
        emit = asg_q[idx_q] && auto_q[idx_q];
        emit_res.result_kind = nmhm_pkg::RK_FRAME;
        emit_res.event_node = 7'(idx_q);
        emit_res.nmt_command = nmhm_pkg::NMT_START;
      end
      default: emit = 1'b0;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      boot_q <= nmhm_pkg::BOOT_TIME_RESET;
      flags_q <= '0;
      running_q <= 1'b0;
      nready_q <= 1'b0;
      btr_q <= 1'b0;
      start_q <= '0;
      latest_q <= '0;
      idx_q <= IW'(1);
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        asg_q[i] <= 1'b0;
        mand_q[i] <= 1'b0;
        auto_q[i] <= 1'b0;
        hbt_q[i] <= '0;
        nst_q[i] <= nmhm_pkg::NS_WAIT;
        lhb_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          nmhm_pkg::CFG_MASTER_ID: mid_q <= cfg_data_i[6:0];
          nmhm_pkg::CFG_BOOT_TIME: boot_q <= cfg_data_i;
          nmhm_pkg::CFG_FLAGS: flags_q <= cfg_data_i;
          default: ;
        endcase
      end

      // output register and pending slot
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (emit) begin
        pend_v_q <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
      end else if (cmd_i == nmhm_pkg::CMD_FLUSH) begin
        pend_v_q <= 1'b0;
        out_v_q <= 1'b1;
      end

      case (cmd_i)
        nmhm_pkg::CMD_CONFIG: begin
          if (emit_res.accepted) begin
            asg_q[cfg_node] <= 1'b1;
            mand_q[cfg_node] <= item_q.mandatory;
            auto_q[cfg_node] <= item_q.autostart_en;
            hbt_q[cfg_node] <= item_q.hb_limit;
            nst_q[cfg_node] <= nmhm_pkg::NS_WAIT;
          end
        end
        nmhm_pkg::CMD_START: begin
          idx_q <= IW'(1);
          if (flags_q[nmhm_pkg::FLAG_START_BIT]) begin
            latest_q <= item_q.now_ms;
            start_q <= item_q.now_ms;
            running_q <= 1'b1;
            nready_q <= 1'b0;
            btr_q <= 1'b0;
          end
        end
        nmhm_pkg::CMD_START_STEP: begin
          if (asg_q[idx_q]) begin
            nst_q[idx_q] <= nmhm_pkg::NS_WAIT;
            lhb_q[idx_q] <= item_q.now_ms;
          end
          idx_q <= st_o.idx_last ? IW'(1) : idx_q + IW'(1);
        end
        nmhm_pkg::CMD_FRAME: begin
          latest_q <= item_q.now_ms;
          if (frame_ok && asg_q[fid]) begin
            lhb_q[fid] <= item_q.now_ms;
            case (item_q.data_byte)
              nmhm_pkg::HB_BOOTUP, nmhm_pkg::HB_PREOP: nst_q[fid] <= nmhm_pkg::NS_PREOP;
              nmhm_pkg::HB_OPER: nst_q[fid] <= nmhm_pkg::NS_OPER;
              nmhm_pkg::HB_STOPPED: nst_q[fid] <= nmhm_pkg::NS_STOP;
              default: ;
            endcase
          end
        end
        nmhm_pkg::CMD_TICK_INIT: begin
          latest_q <= item_q.now_ms;
          idx_q <= IW'(1);
        end
        nmhm_pkg::CMD_TMO_STEP: begin
          if (tmo_hit) nst_q[idx_q] <= nmhm_pkg::NS_TMO;
          idx_q <= st_o.idx_last ? IW'(1) : idx_q + IW'(1);
        end
        nmhm_pkg::CMD_RDY_STEP: idx_q <= st_o.idx_last ? IW'(1) : idx_q + IW'(1);
        nmhm_pkg::CMD_BOOT_EMIT: btr_q <= 1'b1;
        nmhm_pkg::CMD_READY_EMIT: begin
          nready_q <= 1'b1;
          idx_q <= IW'(1);
        end
        nmhm_pkg::CMD_AS_STEP: idx_q <= st_o.idx_last ? IW'(1) : idx_q + IW'(1);
        default: ;
      endcase
    end
  end

  // payload registers, a pending result never carries last
  always_ff @(posedge clk_i) begin
    if (in_fire_i) item_q <= in_item_i;
    if (emit) begin
      pend_q <= emit_res;
      if (pend_v_q) out_q <= pend_q;
    end else if (cmd_i == nmhm_pkg::CMD_FLUSH) begin
      out_q <= pend_last;
    end
    // readiness scan accumulators
    if (cmd_i == nmhm_pkg::CMD_TICK_INIT) begin
      any_q <= 1'b0;
      rdy_q <= 1'b1;
      found_q <= 1'b0;
      first_q <= '0;
    end else if (cmd_i == nmhm_pkg::CMD_RDY_STEP) begin
      if (asg_q[idx_q]) any_q <= 1'b1;
      if (needs_boot) begin
        rdy_q <= 1'b0;
        if (!found_q) begin
          found_q <= 1'b1;
          first_q <= idx_q;
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o = out_q;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int unsigned NodeCount = nmhm_pkg::NODE_COUNT;
  localparam int unsigned DrainCycles = 80;    // outlasts a tick with all three table walks
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned MaxReports = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  nmhm_stream_if #(.T(nmhm_pkg::in_item_t)) in_if ();
  nmhm_stream_if #(.T(nmhm_pkg::res_t))     out_if ();

  nmt_master_heartbeat_monitor_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if.sink),
    .out_if    (out_if.source)
  );

  // pending requests and expected results
  nmhm_pkg::in_item_t req_q[$];
  nmhm_pkg::res_t     nmt_res_q[$];

  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_items;
  int unsigned kind_cnt[8];
  int unsigned ev_cnt[8];

  // shadow of the node table and run state
  bit          nd_asg[NodeCount+1];
  bit          nd_mand[NodeCount+1];
  bit          nd_auto[NodeCount+1];
  logic [15:0] nd_hbt[NodeCount+1];
  logic [2:0]  nd_st[NodeCount+1];
  logic [31:0] nd_last[NodeCount+1];
  bit          sh_running, sh_ready, sh_bt_rep;
  logic [31:0] sh_start, sh_latest;
  // shadow of the registers
  logic [6:0]  sh_master;
  logic [31:0] sh_boot, sh_flags;

  // clock, reset and known input values from time zero
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = nmhm_pkg::CFG_MASTER_ID;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // result predictor
  // ---------------------------------------------------------------------------
  function automatic void add_result(logic [1:0] rk, logic [2:0] ev, int node,
                                     logic [7:0] st, logic [7:0] cmd, bit acc);
    nmhm_pkg::res_t r;
    r.result_kind = rk;
    r.event_type = ev;
    r.event_node = node[6:0];
    r.event_state = st;
    r.event_time = sh_latest;
    r.nmt_command = cmd;
    r.accepted = acc;
    r.last = 1'b0;
    nmt_res_q.push_back(r);
  endfunction

  function automatic bit waits_boot(int i);
    return nd_asg[i] && nd_mand[i] &&
           (nd_st[i] == nmhm_pkg::NS_WAIT || nd_st[i] == nmhm_pkg::NS_TMO);
  endfunction

  function automatic bit nmt_cmd_valid(logic [7:0] c);
    return c == nmhm_pkg::NMT_START || c == nmhm_pkg::NMT_STOP ||
           c == nmhm_pkg::NMT_PREOP || c == nmhm_pkg::NMT_RESET_NODE ||
           c == nmhm_pkg::NMT_RESET_COMM;
  endfunction

  function automatic void tick_nodes(logic [31:0] now);
    bit all_booted;
    bit any_node;
    logic [31:0] age;
    all_booted = 1'b1;
    any_node = 1'b0;
    sh_latest = now;
    // heartbeat supervision pass
    for (int i = 1; i <= NodeCount; i++) begin
      age = now - nd_last[i];
      if (nd_asg[i] && nd_hbt[i] != 0 && age > {16'h0, nd_hbt[i]} &&
          nd_st[i] != nmhm_pkg::NS_TMO) begin
        nd_st[i] = nmhm_pkg::NS_TMO;
        add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_HB_TIMEOUT, i, 8'h0, 8'h0, 1'b0);
      end
    end
    // readiness pass
    for (int i = 1; i <= NodeCount; i++) begin
      if (nd_asg[i]) any_node = 1'b1;
      if (waits_boot(i)) all_booted = 1'b0;
    end
    age = now - sh_start;
    if (!all_booted && sh_boot != 0 && !sh_bt_rep && age > sh_boot) begin
      // only the first node still missing is reported
      for (int i = 1; i <= NodeCount; i++) begin
        if (waits_boot(i) && !sh_bt_rep) begin
          sh_bt_rep = 1'b1;
          add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_BOOT_TIMEOUT, i, 8'h0, 8'h0, 1'b0);
        end
      end
    end else if (!sh_ready && any_node && all_booted) begin
      sh_ready = 1'b1;
      add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_READY, 0, 8'h0, 8'h0, 1'b0);
      if (!sh_flags[nmhm_pkg::FLAG_NO_AUTOSTART_BIT]) begin
        for (int i = 1; i <= NodeCount; i++) begin
          if (nd_asg[i] && nd_auto[i])
            add_result(nmhm_pkg::RK_FRAME, nmhm_pkg::EV_INVALID, i, 8'h0,
                       nmhm_pkg::NMT_START, 1'b0);
        end
      end
    end
  endfunction

  function automatic void rx_frame(nmhm_pkg::in_item_t it);
    int id;
    sh_latest = it.now_ms;
    if (it.dlc != 4'd1 || it.can_id < nmhm_pkg::HB_BASE ||
        it.can_id > nmhm_pkg::HB_BASE + NodeCount) begin
      add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_INVALID, 0, 8'h0, 8'h0, 1'b0);
      return;
    end
    id = int'(it.can_id - nmhm_pkg::HB_BASE);
    if (!nd_asg[id]) return;  // silent for unknown nodes
    nd_last[id] = it.now_ms;
    case (it.data_byte)
      nmhm_pkg::HB_BOOTUP: begin
        nd_st[id] = nmhm_pkg::NS_PREOP;
        add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_BOOTUP, id, it.data_byte, 8'h0, 1'b0);
      end
      nmhm_pkg::HB_PREOP: begin
        nd_st[id] = nmhm_pkg::NS_PREOP;
        add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_HEARTBEAT, id, it.data_byte, 8'h0, 1'b0);
      end
      nmhm_pkg::HB_OPER: begin
        nd_st[id] = nmhm_pkg::NS_OPER;
        add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_HEARTBEAT, id, it.data_byte, 8'h0, 1'b0);
      end
      nmhm_pkg::HB_STOPPED: begin
        nd_st[id] = nmhm_pkg::NS_STOP;
        add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_HEARTBEAT, id, it.data_byte, 8'h0, 1'b0);
      end
      default:
        add_result(nmhm_pkg::RK_EVENT, nmhm_pkg::EV_INVALID, id, it.data_byte, 8'h0, 1'b0);
    endcase
  endfunction

  function automatic void predict_nmt(nmhm_pkg::in_item_t it);
    int first;
    int n;
    first = nmt_res_q.size();
    n = int'(it.node_id);
    case (it.kind)
      nmhm_pkg::KIND_CONFIG: begin
        if (n < 1 || n > NodeCount || it.node_id == sh_master) begin
          add_result(nmhm_pkg::RK_STATUS, nmhm_pkg::EV_INVALID, 0, 8'h0, 8'h0, 1'b0);
        end else begin
          nd_asg[n] = 1'b1;
          nd_mand[n] = it.mandatory;
          nd_auto[n] = it.autostart_en;
          nd_hbt[n] = it.hb_limit;
          nd_st[n] = nmhm_pkg::NS_WAIT;
          add_result(nmhm_pkg::RK_STATUS, nmhm_pkg::EV_INVALID, 0, 8'h0, 8'h0, 1'b1);
        end
      end
      nmhm_pkg::KIND_START: begin
        if (!sh_flags[nmhm_pkg::FLAG_START_BIT]) begin
          add_result(nmhm_pkg::RK_STATUS, nmhm_pkg::EV_INVALID, 0, 8'h0, 8'h0, 1'b0);
        end else begin
          sh_latest = it.now_ms;
          sh_start = it.now_ms;
          sh_running = 1'b1;
          sh_ready = 1'b0;
          sh_bt_rep = 1'b0;
          for (int i = 1; i <= NodeCount; i++) begin
            if (nd_asg[i]) begin
              nd_st[i] = nmhm_pkg::NS_WAIT;
              nd_last[i] = it.now_ms;
            end
          end
          add_result(nmhm_pkg::RK_STATUS, nmhm_pkg::EV_INVALID, 0, 8'h0, 8'h0, 1'b1);
        end
      end
      nmhm_pkg::KIND_FRAME: if (sh_running) rx_frame(it);
      nmhm_pkg::KIND_TICK: if (sh_running) tick_nodes(it.now_ms);
      nmhm_pkg::KIND_REQUEST: begin
        if (!nmt_cmd_valid(it.command) || n > NodeCount) begin
          add_result(nmhm_pkg::RK_STATUS, nmhm_pkg::EV_INVALID, 0, 8'h0, 8'h0, 1'b0);
        end else begin
          add_result(nmhm_pkg::RK_FRAME, nmhm_pkg::EV_INVALID, n, 8'h0, it.command, 1'b0);
          add_result(nmhm_pkg::RK_STATUS, nmhm_pkg::EV_INVALID, 0, 8'h0, 8'h0, 1'b1);
        end
      end
      default: ;  // unknown kinds are ignored
    endcase
    if (nmt_res_q.size() > first) nmt_res_q[nmt_res_q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: one draw of idle cycles per item, with idle-free stretches
  // ---------------------------------------------------------------------------
  int unsigned in_gap;
  bit          in_burst;
  bit          in_take;
  int unsigned in_draw;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_gap <= 0;
      in_burst <= 1'b0;
    end else begin
      in_take = in_if.valid && in_if.ready;
      if (in_take) begin
        predict_nmt(in_if.data);
        kind_cnt[in_if.data.kind]++;
        n_items++;
        void'(req_q.pop_front());
        if ($urandom_range(0, 15) == 0) in_burst <= !in_burst;
        in_draw = in_burst ? 0 : $urandom_range(0, 9);
        if (in_draw == 0 && req_q.size() > 0) begin
          in_if.data <= req_q[0];  // back-to-back transfer
        end else begin
          in_if.valid <= 1'b0;
          in_gap <= in_draw;
        end
      end else if (!in_if.valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (req_q.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data <= req_q[0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  int unsigned    out_stall;
  bit             out_burst;
  int unsigned    out_draw;
  nmhm_pkg::res_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall <= 0;
      out_burst <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      n_results++;
      if (nmt_res_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) $display("unexpected result: %p", got);
      end else begin
        want = nmt_res_q.pop_front();
        if (got.result_kind == nmhm_pkg::RK_EVENT) ev_cnt[got.event_type]++;
        if (got.result_kind !== want.result_kind || got.event_type !== want.event_type ||
            got.event_node !== want.event_node || got.event_state !== want.event_state ||
            got.event_time !== want.event_time || got.nmt_command !== want.nmt_command ||
            got.accepted !== want.accepted || got.last !== want.last) begin
          n_errors++;
          if (n_errors <= MaxReports) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected kind=%0d ev=%0d node=%0d st=%0d ts=%h cmd=%0d acc=%0d last=%0d",
                     want.result_kind, want.event_type, want.event_node, want.event_state,
                     want.event_time, want.nmt_command, want.accepted, want.last);
            $display("  actual   kind=%0d ev=%0d node=%0d st=%0d ts=%h cmd=%0d acc=%0d last=%0d",
                     got.result_kind, got.event_type, got.event_node, got.event_state,
                     got.event_time, got.nmt_command, got.accepted, got.last);
          end
        end
      end
      if ($urandom_range(0, 15) == 0) out_burst <= !out_burst;
      out_draw = out_burst ? 0 : $urandom_range(0, 9);
      if (out_draw != 0) begin
        out_if.ready <= 1'b0;
        out_stall <= out_draw - 1;
      end
    end else if (!out_if.ready) begin
      if (out_stall > 0) out_stall <= out_stall - 1;
      else out_if.ready <= 1'b1;
    end
  end

  // watchdog: cycles without any transfer
  int unsigned quiet_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic nmhm_pkg::in_item_t noise_item();
    nmhm_pkg::in_item_t it;
    it.kind = 3'($urandom_range(0, 7));
    it.node_id = 7'($urandom);
    it.mandatory = 1'($urandom);
    it.autostart_en = 1'($urandom);
    it.hb_limit = 16'($urandom);
    it.can_id = 11'($urandom);
    it.dlc = 4'($urandom);
    it.data_byte = 8'($urandom);
    it.now_ms = $urandom;
    it.command = 8'($urandom);
    return it;
  endfunction

  function automatic nmhm_pkg::in_item_t cfg_node(int node, bit mand, bit auto_st,
                                                  logic [15:0] hbt);
    nmhm_pkg::in_item_t it;
    it = noise_item();
    it.kind = nmhm_pkg::KIND_CONFIG;
    it.node_id = node[6:0];
    it.mandatory = mand;
    it.autostart_en = auto_st;
    it.hb_limit = hbt;
    return it;
  endfunction

  function automatic nmhm_pkg::in_item_t timed(logic [2:0] kind, logic [31:0] now);
    nmhm_pkg::in_item_t it;
    it = noise_item();
    it.kind = kind;
    it.now_ms = now;
    return it;
  endfunction

  function automatic nmhm_pkg::in_item_t hb_frame(logic [10:0] id, logic [3:0] dlc,
                                                  logic [7:0] st, logic [31:0] now);
    nmhm_pkg::in_item_t it;
    it = timed(nmhm_pkg::KIND_FRAME, now);
    it.can_id = id;
    it.dlc = dlc;
    it.data_byte = st;
    return it;
  endfunction

  function automatic nmhm_pkg::in_item_t nmt_req(int node, logic [7:0] cmd);
    nmhm_pkg::in_item_t it;
    it = noise_item();
    it.kind = nmhm_pkg::KIND_REQUEST;
    it.node_id = node[6:0];
    it.command = cmd;
    return it;
  endfunction

  // registers are only written with the block idle
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      nmhm_pkg::CFG_MASTER_ID: sh_master = val[6:0];
      nmhm_pkg::CFG_BOOT_TIME: sh_boot = val;
      nmhm_pkg::CFG_FLAGS: sh_flags = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || nmt_res_q.size() != 0 || in_if.valid) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one phase of mostly well-formed traffic: configure, start, heartbeats, ticks, nmt requests, restarts, noise
  task automatic random_phase(int unsigned n_req);
    logic [31:0] t;
    int unsigned r;
    logic [7:0] st;
    logic [10:0] id;
    int unsigned n_cfg;
    t = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
    n_cfg = $urandom_range(2, 6);
    for (int k = 0; k < n_cfg; k++)
      req_q.push_back(cfg_node(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, NodeCount),
                               1'($urandom), 1'($urandom),
                               ($urandom_range(0, 3) == 0) ? 16'h0 :
                               ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(20, 300))));
    req_q.push_back(timed(nmhm_pkg::KIND_START, t));
    for (int k = n_cfg + 1; k < n_req; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        req_q.push_back(noise_item());
      end else if (r < 50) begin
        t += $urandom_range(0, 40);
        case ($urandom_range(0, 5))
          0: st = nmhm_pkg::HB_BOOTUP;
          1: st = nmhm_pkg::HB_PREOP;
          2: st = nmhm_pkg::HB_OPER;
          3: st = nmhm_pkg::HB_STOPPED;
          4: st = nmhm_pkg::HB_BOOTUP;
          default: st = 8'($urandom);
        endcase
        id = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                         : nmhm_pkg::HB_BASE + 11'($urandom_range(0, NodeCount));
        req_q.push_back(hb_frame(id, ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd1, st, t));
      end else if (r < 80) begin
        t += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 150);
        req_q.push_back(timed(nmhm_pkg::KIND_TICK, t));
      end else if (r < 88) begin
        req_q.push_back(nmt_req($urandom_range(0, 20), ($urandom_range(0, 1) == 0) ?
                                8'($urandom) : nmhm_pkg::NMT_START));
      end else if (r < 94) begin
        req_q.push_back(cfg_node($urandom_range(1, NodeCount), 1'($urandom), 1'($urandom),
                                 16'($urandom_range(0, 300))));
      end else begin
        t += $urandom_range(0, 50);
        req_q.push_back(timed(nmhm_pkg::KIND_START, t));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i <= NodeCount; i++) begin
      nd_asg[i] = 1'b0;
      nd_mand[i] = 1'b0;
      nd_auto[i] = 1'b0;
      nd_hbt[i] = '0;
      nd_st[i] = nmhm_pkg::NS_WAIT;
      nd_last[i] = '0;
    end
    sh_running = 1'b0;
    sh_ready = 1'b0;
    sh_bt_rep = 1'b0;
    sh_start = '0;
    sh_latest = '0;
    sh_master = '0;
    sh_boot = nmhm_pkg::BOOT_TIME_RESET;
    sh_flags = '0;
    n_errors = 0;
    n_results = 0;
    n_items = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // not running yet: frame and tick are silent, start is refused
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd1, 4'd1, nmhm_pkg::HB_BOOTUP, 32'd5));
    req_q.push_back(timed(nmhm_pkg::KIND_TICK, 32'd6));
    req_q.push_back(timed(nmhm_pkg::KIND_START, 32'd7));
    // node id out of range or equal to own id, then three valid nodes
    req_q.push_back(cfg_node(0, 1'b1, 1'b1, 16'd10));
    req_q.push_back(cfg_node(NodeCount + 1, 1'b1, 1'b1, 16'd10));
    req_q.push_back(cfg_node(127, 1'b0, 1'b0, 16'hFFFF));
    req_q.push_back(cfg_node(1, 1'b1, 1'b1, 16'd100));
    req_q.push_back(cfg_node(NodeCount, 1'b0, 1'b1, 16'hFFFF));
    req_q.push_back(cfg_node(3, 1'b1, 1'b0, 16'd0));
    // every nmt command, a bad command, a node out of range
    req_q.push_back(nmt_req(0, nmhm_pkg::NMT_START));
    req_q.push_back(nmt_req(NodeCount, nmhm_pkg::NMT_STOP));
    req_q.push_back(nmt_req(1, nmhm_pkg::NMT_PREOP));
    req_q.push_back(nmt_req(2, nmhm_pkg::NMT_RESET_NODE));
    req_q.push_back(nmt_req(127, nmhm_pkg::NMT_RESET_COMM));
    req_q.push_back(nmt_req(3, 8'd255));
    // unknown kinds
    for (int k = 5; k <= 7; k++) req_q.push_back(timed(3'(k), 32'd9));
    wait_idle();

    reg_write(nmhm_pkg::CFG_FLAGS, 32'h1);
    // start just before the time wraps
    req_q.push_back(timed(nmhm_pkg::KIND_START, 32'hFFFF_FFF0));
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd1, 4'd1, nmhm_pkg::HB_BOOTUP,
                             32'hFFFF_FFF2));
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'(NodeCount), 4'd1, nmhm_pkg::HB_PREOP,
                             32'hFFFF_FFF3));
    // id 0: silent
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE, 4'd1, nmhm_pkg::HB_OPER, 32'hFFFF_FFF4));
    // unassigned node
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd2, 4'd1, nmhm_pkg::HB_OPER,
                             32'hFFFF_FFF5));
    // bad length, id out of range
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd3, 4'd2, nmhm_pkg::HB_OPER,
                             32'hFFFF_FFF6));
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'(NodeCount + 1), 4'd1, nmhm_pkg::HB_OPER,
                             32'hFFFF_FFF7));
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd3, 4'd1, nmhm_pkg::HB_OPER,
                             32'hFFFF_FFF8));
    // bad state
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd3, 4'd1, 8'd77, 32'hFFFF_FFF9));
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd3, 4'd1, nmhm_pkg::HB_STOPPED,
                             32'hFFFF_FFFA));
    // wrapped time: node 1 misses its heartbeat
    req_q.push_back(timed(nmhm_pkg::KIND_TICK, 32'h0000_0100));
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd1, 4'd1, nmhm_pkg::HB_BOOTUP,
                             32'h0000_0101));
    req_q.push_back(timed(nmhm_pkg::KIND_TICK, 32'h0000_0102));  // ready, auto-start
    req_q.push_back(timed(nmhm_pkg::KIND_TICK, 32'h0000_6000));  // node 1 times out
    wait_idle();

    // restart with node 1 never booting: boot timeout
    req_q.push_back(timed(nmhm_pkg::KIND_START, 32'd0));
    req_q.push_back(hb_frame(nmhm_pkg::HB_BASE + 11'd3, 4'd1, nmhm_pkg::HB_BOOTUP, 32'd1));
    req_q.push_back(timed(nmhm_pkg::KIND_TICK, 32'd20000));
    wait_idle();

    reg_write(nmhm_pkg::CFG_MASTER_ID, 32'd127);
    reg_write(nmhm_pkg::CFG_BOOT_TIME, 32'hFFFF_FFFF);
    reg_write(nmhm_pkg::CFG_FLAGS, 32'hFFFF_FFFF);
    random_phase(32);
    wait_idle();

    reg_write(nmhm_pkg::CFG_MASTER_ID, 32'd5);
    reg_write(nmhm_pkg::CFG_BOOT_TIME, 32'd0);
    reg_write(nmhm_pkg::CFG_FLAGS, 32'h1);
    random_phase(32);
    wait_idle();

    reg_write(nmhm_pkg::CFG_MASTER_ID, $urandom);
    reg_write(nmhm_pkg::CFG_BOOT_TIME, 32'd200);
    reg_write(nmhm_pkg::CFG_FLAGS, 32'h9);
    random_phase(32);
    wait_idle();

    reg_write(nmhm_pkg::CFG_MASTER_ID, 32'd0);
    reg_write(nmhm_pkg::CFG_BOOT_TIME, 32'd50);
    reg_write(nmhm_pkg::CFG_FLAGS, $urandom | 32'h1);
    random_phase(32);
    wait_idle();

    $display("covered %0d requests (cfg %0d, start %0d, frame %0d, tick %0d, nmt %0d, other %0d)",
             n_items, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4],
             kind_cnt[5] + kind_cnt[6] + kind_cnt[7]);
    $display("checked %0d results: bootup %0d, hb %0d, hb timeout %0d, boot timeout %0d, ready %0d",
             n_results, ev_cnt[1], ev_cnt[2], ev_cnt[3], ev_cnt[4], ev_cnt[5]);
    if (n_errors == 0 && nmt_res_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_errors, nmt_res_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
